// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks in the encoder modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// The consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/b91enc_pkg.sv -----
// ----------------------------------------------------------------------------
// b91enc_pkg
// Types and constants shared by the base-91 value encoder modules.
// ----------------------------------------------------------------------------
package b91enc_pkg;

    localparam int BYTE_W  = 8;
    localparam int DIGIT_W = 7;
    localparam int ACC_W   = 13;    // bits held between transactions
    localparam int CNT_W   = 4;     // bit count between transactions, 0 to 13
    localparam int SUM_W   = 5;     // bit count after a byte is absorbed, 8 to 21
    localparam int WIDE_W  = 21;    // accumulator width after a byte is absorbed
    localparam int X_W     = 14;    // widest value handed to the divider

    localparam int SHORT_BITS     = 13;
    localparam int LONG_BITS      = 14;
    localparam int SHORT_MIN      = 88;   // a 13-bit group must exceed this
    localparam int BASE           = 91;
    localparam int DIGIT_MAX      = 90;
    localparam int FLUSH_ONE_BITS = 7;

    // Division by 91 as multiplication by ceil(2^20 / 91); exact for x < 2^14.
    localparam int RECIP       = 11523;
    localparam int RECIP_W     = 14;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = X_W + RECIP_W;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit_value;
        logic               last_digit;
    } t_out_item;

    // One value to split into digits: x % 91, then x / 91 when div is set.
    typedef struct packed {
        logic [X_W-1:0] x;
        logic           div;
        logic           last;
    } t_op;

    // Work for one input byte: the extracted group and the flushed remainder.
    typedef struct packed {
        logic op0_en;
        t_op  op0;
        logic op1_en;
        t_op  op1;
    } t_job;

endpackage

// ----- src/b91enc_front.sv -----
// ----------------------------------------------------------------------------
// b91enc_front
// Absorbs input bytes into the bit accumulator, extracts 13- or 14-bit groups
// and the flush remainder, and queues them as divider work.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b91enc_front import b91enc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_data,
    input  logic     i_queue_full,
    output logic     o_push,
    output t_job     o_job
);

    logic [ACC_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_cnt;

    logic              accept;
    logic [WIDE_W-1:0] wide_acc;
    logic [SUM_W-1:0]  sum_cnt;
    logic              extract;
    logic              take_short;
    logic [X_W-1:0]    group_val;
    logic [WIDE_W-1:0] rest_acc;
    logic [SUM_W-1:0]  rest_cnt;
    logic              flush;
    logic [ACC_W-1:0]  rest_val;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        wide_acc   = WIDE_W'(r_acc) | (WIDE_W'(i_data.data_byte) << r_cnt);
        sum_cnt    = SUM_W'(r_cnt) + SUM_W'(BYTE_W);
        extract    = sum_cnt > SUM_W'(SHORT_BITS);
        take_short = wide_acc[SHORT_BITS-1:0] > SHORT_BITS'(SHORT_MIN);
        group_val  = take_short ? X_W'(wide_acc[SHORT_BITS-1:0]) : wide_acc[LONG_BITS-1:0];
        if (!extract) begin
            rest_acc = wide_acc;
            rest_cnt = sum_cnt;
        end else if (take_short) begin
            rest_acc = wide_acc >> SHORT_BITS;
            rest_cnt = sum_cnt - SUM_W'(SHORT_BITS);
        end else begin
            rest_acc = wide_acc >> LONG_BITS;
            rest_cnt = sum_cnt - SUM_W'(LONG_BITS);
        end
        rest_val = rest_acc[ACC_W-1:0];
        flush    = i_data.end_of_message && (rest_cnt != '0);
    end

    always_comb begin
        o_job.op0_en    = extract;
        o_job.op0.x     = group_val;
        o_job.op0.div   = 1'b1;
        o_job.op0.last  = i_data.end_of_message && !flush;
        o_job.op1_en    = flush;
        o_job.op1.x     = X_W'(rest_val);
        o_job.op1.div   = (rest_cnt > SUM_W'(FLUSH_ONE_BITS))
                          || (rest_val > ACC_W'(DIGIT_MAX));
        o_job.op1.last  = 1'b1;
        o_push          = accept && (extract || flush);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (accept) begin
            if (i_data.end_of_message) begin
                r_acc <= '0;
                r_cnt <= '0;
            end else begin
                r_acc <= rest_val;
                r_cnt <= rest_cnt[CNT_W-1:0];
            end
        end
    end

    `ASSERT_ALWAYS(a_cnt_range, r_cnt <= CNT_W'(SHORT_BITS), "bit count above 13")
    `ASSERT_ALWAYS(a_acc_clean, (r_acc >> r_cnt) == '0, "accumulator holds bits above count")

endmodule

// ----- src/b91enc_fifo.sv -----
// ----------------------------------------------------------------------------
// b91enc_fifo
// Short job queue between the accumulator front and the divider back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b91enc_fifo import b91enc_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_head_valid,
    output t_job o_head,
    input  logic i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        next_ptr = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign o_full       = r_count == CNT_W'(DEPTH);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, i_push, !o_full || i_pop, "push into a full queue")
    `ASSERT_IMPLIES(a_no_underflow, i_pop, o_head_valid, "pop from an empty queue")

endmodule

// ----- src/b91enc_back.sv -----
// ----------------------------------------------------------------------------
// b91enc_back
// Takes queued values one at a time, divides each by 91 in a two-stage
// reciprocal unit; emits remainder, then quotient if div, via output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b91enc_back import b91enc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_job      i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic               r_sel;
    logic               r_d_valid;
    t_op                r_d_op;
    logic               r_e_valid;
    t_op                r_e_op;
    logic [DIGIT_W-1:0] r_e_q;
    logic               r_e_phase;
    logic               r_o_valid;
    t_out_item          r_o_item;

    logic               use_op0;
    t_op                sel_op;
    logic               fetch;
    logic [PROD_W-1:0]  prod;
    logic [X_W:0]       q_times_base;
    logic [X_W:0]       rem_full;
    t_out_item          digit;
    logic               out_load;
    logic               e_emit;
    logic               e_done;
    logic               e_free;
    logic               d_move;
    logic               d_free;

    always_comb begin
        out_load = !r_o_valid || i_ready;
        e_emit   = r_e_valid && out_load;
        e_done   = e_emit && (r_e_phase || !r_e_op.div);
        e_free   = !r_e_valid || e_done;
        d_move   = r_d_valid && e_free;
        d_free   = !r_d_valid || d_move;
        fetch    = i_head_valid && d_free;
        use_op0  = i_head.op0_en && !r_sel;
        sel_op   = use_op0 ? i_head.op0 : i_head.op1;
        // The job leaves the queue with its final value.
        o_pop    = fetch && (!use_op0 || !i_head.op1_en);
    end

    always_comb begin
        prod         = PROD_W'(r_d_op.x) * PROD_W'(RECIP);
        q_times_base = (X_W + 1)'(r_e_q) * (X_W + 1)'(BASE);
        rem_full     = {1'b0, r_e_op.x} - q_times_base;
        if (r_e_phase) begin
            digit.digit_value = r_e_q;
            digit.last_digit  = r_e_op.last;
        end else begin
            digit.digit_value = rem_full[DIGIT_W-1:0];
            digit.last_digit  = r_e_op.last && !r_e_op.div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel     <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_e_phase <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_sel <= 1'b0;
            end else if (fetch) begin
                r_sel <= 1'b1;
            end

            if (fetch) begin
                r_d_valid <= 1'b1;
            end else if (d_move) begin
                r_d_valid <= 1'b0;
            end

            if (d_move) begin
                r_e_valid <= 1'b1;
                r_e_phase <= 1'b0;
            end else if (e_done) begin
                r_e_valid <= 1'b0;
            end else if (e_emit) begin
                r_e_phase <= 1'b1;
            end

            if (out_load) begin
                r_o_valid <= e_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fetch) begin
            r_d_op <= sel_op;
        end
        if (d_move) begin
            r_e_op <= r_d_op;
            r_e_q  <= prod[RECIP_SHIFT +: DIGIT_W];
        end
        if (out_load && e_emit) begin
            r_o_item <= digit;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_item;

    `ASSERT_IMPLIES(a_phase_div, r_e_valid && r_e_phase, r_e_op.div,
        "quotient phase on a value that emits one digit")
    `ASSERT_IMPLIES(a_digit_range, r_o_valid, r_o_item.digit_value <= DIGIT_W'(DIGIT_MAX),
        "digit value above 90")

endmodule

// ----- src/base91_value_encoder_top.sv -----
// ----------------------------------------------------------------------------
// base91_value_encoder_top
// Base-91 encoder core that turns a byte stream into base-91 digit values.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while its job queue has room and gives
// one digit per cycle on the output while it is ready, so a byte yields
// between zero and four digits: none when it only fills the accumulator, two
// when it completes a 13- or 14-bit group, and up to four on a final byte that
// also flushes. The rate is set by the single shared divide-by-91 unit, which
// emits the remainder and then the quotient of each value (only the remainder
// for a flushed value that gives one digit) and can take the next value while
// the last one is still emitting its digits. A byte's first digit passes
// through the queue, the operand register, the quotient register after the
// reciprocal multiply, then the output register. When the output stalls, the
// queue absorbs up to P_QUEUE_DEPTH jobs before the input stops accepting.
module base91_value_encoder_top import b91enc_pkg::*; #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic queue_full;
    logic push;
    t_job push_job;
    logic head_valid;
    t_job head_job;
    logic pop;

    b91enc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    b91enc_fifo #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (push_job),
        .o_full       (queue_full),
        .o_head_valid (head_valid),
        .o_head       (head_job),
        .i_pop        (pop)
    );

    b91enc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_job),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (o_data)
    );

endmodule
